// ----- hdl/svm_pkg.sv -----
// Shared constants, codes, command and status types for the stack VM execute unit.
// Used by svm_ctrl, svm_datapath and the top level; depends on nothing.
package svm_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int NUM_REGS  = 16;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int RIDX_W    = $clog2(NUM_REGS);

   localparam logic [RIDX_W-1:0] SP_IDX = RIDX_W'(NUM_REGS - 3);
   localparam logic [RIDX_W-1:0] BP_IDX = RIDX_W'(NUM_REGS - 2);
   localparam logic [RIDX_W-1:0] PC_IDX = RIDX_W'(NUM_REGS - 1);
   localparam logic [63:0] MEM_END = 64'(MEM_BYTES);

   localparam logic [7:0] CSR_STACK_LIMIT    = 8'd0;
   localparam logic [7:0] CSR_PROGRAM_LENGTH = 8'd1;

   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_ENTRY   = 5'd1;
   localparam logic [4:0] OP_MOVE    = 5'd2;
   localparam logic [4:0] OP_LDI     = 5'd3;
   localparam logic [4:0] OP_LOAD    = 5'd4;
   localparam logic [4:0] OP_STORE   = 5'd5;
   localparam logic [4:0] OP_SYSCALL = 5'd6;
   localparam logic [4:0] OP_JMP     = 5'd7;
   localparam logic [4:0] OP_JMPIF   = 5'd8;
   localparam logic [4:0] OP_PUSH    = 5'd9;
   localparam logic [4:0] OP_PUSHI   = 5'd10;
   localparam logic [4:0] OP_POP     = 5'd11;
   localparam logic [4:0] OP_CALL    = 5'd12;
   localparam logic [4:0] OP_RET     = 5'd13;
   localparam logic [4:0] OP_INC     = 5'd14;
   localparam logic [4:0] OP_DEC     = 5'd15;
   localparam logic [4:0] OP_NEG     = 5'd16;
   localparam logic [4:0] OP_NOT     = 5'd17;
   localparam logic [4:0] OP_ADD     = 5'd18;
   localparam logic [4:0] OP_SUB     = 5'd19;
   localparam logic [4:0] OP_MUL     = 5'd20;
   localparam logic [4:0] OP_DIV     = 5'd21;
   localparam logic [4:0] OP_MOD     = 5'd22;
   localparam logic [4:0] OP_AND     = 5'd23;
   localparam logic [4:0] OP_OR      = 5'd24;
   localparam logic [4:0] OP_XOR     = 5'd25;
   localparam logic [4:0] OP_SHL     = 5'd26;
   localparam logic [4:0] OP_SHR     = 5'd27;

   localparam logic [3:0] TRAP_NONE      = 4'd0;
   localparam logic [3:0] TRAP_ACCESS    = 4'd1;
   localparam logic [3:0] TRAP_SIZE      = 4'd2;
   localparam logic [3:0] TRAP_JUMP      = 4'd3;
   localparam logic [3:0] TRAP_OVERFLOW  = 4'd4;
   localparam logic [3:0] TRAP_UNDERFLOW = 4'd5;
   localparam logic [3:0] TRAP_REGISTER  = 4'd6;
   localparam logic [3:0] TRAP_SYSCALL   = 4'd7;
   localparam logic [3:0] TRAP_DIV_ZERO  = 4'd8;
   localparam logic [3:0] TRAP_BAD_INST  = 4'd9;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_RD1, ST_RD2, ST_EXEC, ST_ALU, ST_WB,
      ST_MRD, ST_MACC, ST_MWR, ST_PUSH_CHK, ST_PUSH_SP, ST_CALL_BP,
      ST_POP_CHK, ST_POP_WR, ST_POP_SP, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {RI_X, RI_Y, RI_Z, RI_BP, RI_PC} ridx_type;
   typedef enum logic [1:0] {WD_X, WD_SP, WD_BP, WD_PC} wdst_type;
   typedef enum logic [2:0] {
      WS_A, WS_IMM, WS_ALU, WS_UNARY, WS_DATA, WS_ADDR, WS_ADDR_P8, WS_BP_VAL
   } wsrc_type;
   typedef enum logic [1:0] {AS_A, AS_SP, AS_SP_M8} asel_type;
   typedef enum logic [2:0] {
      RS_X, RS_A, RS_SIZE, RS_A_SIZE, RS_MEM, RS_IMM, RS_SP, RS_IADDR
   } rsel_type;

   typedef struct packed {
      logic       latch;
      ridx_type   rd_idx;
      logic       ld_a;
      logic       ld_b;
      logic       b_imm;
      logic       wr_en;
      wdst_type   wr_dst;
      wsrc_type   wr_src;
      logic       addr_setup;
      asel_type   addr_sel;
      logic       len8;
      logic       mem_rd;
      logic       mem_acc;
      logic       mem_wr;
      logic       alu_start;
      logic       alu_step;
      logic       set_trap;
      logic [3:0] trap_code;
      rsel_type   reason_sel;
      logic       set_npc;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic [4:0] op;
      logic       x_special;
      logic       b_nz;
      logic       a_ge_mem;
      logic       size_gt8;
      logic       end_ge_mem;
      logic       a_ge_plen;
      logic       push_ovf;
      logic       pop_unf;
      logic       cnt_done;
      logic       div_zero;
      logic       alu_done;
      logic       out_free;
   } status_type;

   function automatic logic is_binary(input logic [4:0] op);
      return (op >= OP_ADD) && (op <= OP_SHR);
   endfunction

   function automatic logic is_unary(input logic [4:0] op);
      return (op >= OP_INC) && (op <= OP_NOT);
   endfunction

   function automatic logic is_muldiv(input logic [4:0] op);
      return (op == OP_MUL) || (op == OP_DIV) || (op == OP_MOD);
   endfunction

endpackage

// ----- hdl/svm_ctrl.sv -----
// Sequencing state machine of the stack VM execute unit.
// Depends on svm_pkg; drives svm_datapath through a command struct.
module svm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  svm_pkg::status_type status,
   output svm_pkg::cmd_type    cmd
);

   svm_pkg::state_type state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [4:0]         op;

   assign op        = status.op;
   assign req_stall = (state_ff != svm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svm_pkg::ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (state_ff == svm_pkg::ST_DECODE) begin
         phase_in = 1'b0;
      end else if (state_ff == svm_pkg::ST_PUSH_SP || state_ff == svm_pkg::ST_POP_SP) begin
         phase_in = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svm_pkg::ST_IDLE: begin
            if (req_valid) state_in = svm_pkg::ST_DECODE;
         end
         svm_pkg::ST_DECODE: begin
            case (op)
               svm_pkg::OP_NOP, svm_pkg::OP_ENTRY, svm_pkg::OP_LDI,
               svm_pkg::OP_SYSCALL: state_in = svm_pkg::ST_FINISH;
               svm_pkg::OP_MOVE:
                  state_in = status.x_special ? svm_pkg::ST_FINISH : svm_pkg::ST_RD1;
               svm_pkg::OP_PUSHI, svm_pkg::OP_CALL: state_in = svm_pkg::ST_PUSH_CHK;
               svm_pkg::OP_POP, svm_pkg::OP_RET: state_in = svm_pkg::ST_POP_CHK;
               default: begin
                  if (op > svm_pkg::OP_SHR) state_in = svm_pkg::ST_FINISH;
                  else state_in = svm_pkg::ST_RD1;
               end
            endcase
         end
         svm_pkg::ST_RD1: begin
            if (op == svm_pkg::OP_STORE || op == svm_pkg::OP_JMPIF || svm_pkg::is_binary(op))
               state_in = svm_pkg::ST_RD2;
            else if (op == svm_pkg::OP_PUSH)
               state_in = svm_pkg::ST_PUSH_CHK;
            else
               state_in = svm_pkg::ST_EXEC;
         end
         svm_pkg::ST_RD2: begin
            if (op == svm_pkg::OP_JMPIF && !status.b_nz) state_in = svm_pkg::ST_FINISH;
            else state_in = svm_pkg::ST_EXEC;
         end
         svm_pkg::ST_EXEC: begin
            state_in = svm_pkg::ST_FINISH;
            if (op == svm_pkg::OP_LOAD || op == svm_pkg::OP_STORE) begin
               if (!status.a_ge_mem && !status.size_gt8 && !status.end_ge_mem)
                  state_in = (op == svm_pkg::OP_LOAD) ? svm_pkg::ST_MRD : svm_pkg::ST_MWR;
            end else if (svm_pkg::is_muldiv(op)) begin
               if (op == svm_pkg::OP_MUL || !status.div_zero) state_in = svm_pkg::ST_ALU;
            end
         end
         svm_pkg::ST_ALU: begin
            if (status.alu_done) state_in = svm_pkg::ST_WB;
         end
         svm_pkg::ST_WB: state_in = svm_pkg::ST_FINISH;
         svm_pkg::ST_MRD: begin
            if (status.cnt_done)
               state_in = (op == svm_pkg::OP_LOAD) ? svm_pkg::ST_FINISH : svm_pkg::ST_POP_WR;
            else
               state_in = svm_pkg::ST_MACC;
         end
         svm_pkg::ST_MACC: state_in = svm_pkg::ST_MRD;
         svm_pkg::ST_MWR: begin
            if (status.cnt_done)
               state_in = (op == svm_pkg::OP_STORE) ? svm_pkg::ST_FINISH : svm_pkg::ST_PUSH_SP;
         end
         svm_pkg::ST_PUSH_CHK:
            state_in = status.push_ovf ? svm_pkg::ST_FINISH : svm_pkg::ST_MWR;
         svm_pkg::ST_PUSH_SP: begin
            if (op == svm_pkg::OP_CALL)
               state_in = phase_ff ? svm_pkg::ST_CALL_BP : svm_pkg::ST_PUSH_CHK;
            else
               state_in = svm_pkg::ST_FINISH;
         end
         svm_pkg::ST_CALL_BP: state_in = svm_pkg::ST_RD1;
         svm_pkg::ST_POP_CHK:
            state_in = status.pop_unf ? svm_pkg::ST_FINISH : svm_pkg::ST_MRD;
         svm_pkg::ST_POP_WR: state_in = svm_pkg::ST_POP_SP;
         svm_pkg::ST_POP_SP: begin
            if (op == svm_pkg::OP_RET)
               state_in = phase_ff ? svm_pkg::ST_RD1 : svm_pkg::ST_POP_CHK;
            else
               state_in = svm_pkg::ST_FINISH;
         end
         svm_pkg::ST_FINISH: begin
            if (status.out_free) state_in = svm_pkg::ST_IDLE;
         end
         default: state_in = svm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         svm_pkg::ST_IDLE: cmd.latch = req_valid;
         svm_pkg::ST_DECODE: begin
            case (op)
               svm_pkg::OP_MOVE: begin
                  if (status.x_special) begin
                     cmd.set_trap   = 1'b1;
                     cmd.trap_code  = svm_pkg::TRAP_REGISTER;
                     cmd.reason_sel = svm_pkg::RS_X;
                  end
               end
               svm_pkg::OP_LDI: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_dst = svm_pkg::WD_X;
                  cmd.wr_src = svm_pkg::WS_IMM;
               end
               svm_pkg::OP_SYSCALL: begin
                  cmd.set_trap   = 1'b1;
                  cmd.trap_code  = svm_pkg::TRAP_SYSCALL;
                  cmd.reason_sel = svm_pkg::RS_IMM;
               end
               svm_pkg::OP_PUSHI: cmd.b_imm = 1'b1;
               svm_pkg::OP_RET: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_dst = svm_pkg::WD_SP;
                  cmd.wr_src = svm_pkg::WS_BP_VAL;
               end
               svm_pkg::OP_CALL: begin
                  cmd.rd_idx = svm_pkg::RI_BP;
                  cmd.ld_b   = 1'b1;
               end
               default: begin
                  if (op > svm_pkg::OP_SHR) begin
                     cmd.set_trap   = 1'b1;
                     cmd.trap_code  = svm_pkg::TRAP_BAD_INST;
                     cmd.reason_sel = svm_pkg::RS_IADDR;
                  end
               end
            endcase
         end
         svm_pkg::ST_RD1: begin
            case (op)
               svm_pkg::OP_JMPIF: begin
                  cmd.rd_idx = svm_pkg::RI_Y;
                  cmd.ld_b   = 1'b1;
               end
               svm_pkg::OP_PUSH: begin
                  cmd.rd_idx = svm_pkg::RI_X;
                  cmd.ld_b   = 1'b1;
               end
               svm_pkg::OP_RET: begin
                  cmd.rd_idx = svm_pkg::RI_PC;
                  cmd.ld_a   = 1'b1;
               end
               svm_pkg::OP_MOVE, svm_pkg::OP_LOAD: begin
                  cmd.rd_idx = svm_pkg::RI_Y;
                  cmd.ld_a   = 1'b1;
               end
               default: begin
                  cmd.rd_idx = svm_pkg::is_binary(op) ? svm_pkg::RI_Y : svm_pkg::RI_X;
                  cmd.ld_a   = 1'b1;
               end
            endcase
         end
         svm_pkg::ST_RD2: begin
            if (op == svm_pkg::OP_JMPIF) begin
               cmd.rd_idx = svm_pkg::RI_X;
               cmd.ld_a   = status.b_nz;
            end else begin
               cmd.rd_idx = (op == svm_pkg::OP_STORE) ? svm_pkg::RI_Y : svm_pkg::RI_Z;
               cmd.ld_b   = 1'b1;
            end
         end
         svm_pkg::ST_EXEC: begin
            case (op)
               svm_pkg::OP_MOVE: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_dst = svm_pkg::WD_X;
                  cmd.wr_src = svm_pkg::WS_A;
               end
               svm_pkg::OP_LOAD, svm_pkg::OP_STORE: begin
                  cmd.trap_code = svm_pkg::TRAP_ACCESS;
                  if (status.a_ge_mem) begin
                     cmd.set_trap   = 1'b1;
                     cmd.reason_sel = svm_pkg::RS_A;
                  end else if (status.size_gt8) begin
                     cmd.set_trap   = 1'b1;
                     cmd.trap_code  = svm_pkg::TRAP_SIZE;
                     cmd.reason_sel = svm_pkg::RS_SIZE;
                  end else if (status.end_ge_mem) begin
                     cmd.set_trap   = 1'b1;
                     cmd.reason_sel = (op == svm_pkg::OP_LOAD) ? svm_pkg::RS_A_SIZE
                                                               : svm_pkg::RS_MEM;
                  end else begin
                     cmd.addr_setup = 1'b1;
                     cmd.addr_sel   = svm_pkg::AS_A;
                  end
               end
               svm_pkg::OP_JMP, svm_pkg::OP_JMPIF, svm_pkg::OP_CALL, svm_pkg::OP_RET: begin
                  if (status.a_ge_plen) begin
                     cmd.set_trap   = 1'b1;
                     cmd.trap_code  = svm_pkg::TRAP_JUMP;
                     cmd.reason_sel = svm_pkg::RS_A;
                  end else begin
                     cmd.set_npc = 1'b1;
                  end
               end
               default: begin
                  if (svm_pkg::is_unary(op)) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_dst = svm_pkg::WD_X;
                     cmd.wr_src = svm_pkg::WS_UNARY;
                  end else if (svm_pkg::is_muldiv(op)) begin
                     if (op != svm_pkg::OP_MUL && status.div_zero) begin
                        cmd.set_trap   = 1'b1;
                        cmd.trap_code  = svm_pkg::TRAP_DIV_ZERO;
                        cmd.reason_sel = svm_pkg::RS_IADDR;
                     end else begin
                        cmd.alu_start = 1'b1;
                     end
                  end else if (svm_pkg::is_binary(op)) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_dst = svm_pkg::WD_X;
                     cmd.wr_src = svm_pkg::WS_ALU;
                  end
               end
            endcase
         end
         svm_pkg::ST_ALU: cmd.alu_step = 1'b1;
         svm_pkg::ST_WB: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_dst = svm_pkg::WD_X;
            cmd.wr_src = svm_pkg::WS_ALU;
         end
         svm_pkg::ST_MRD: begin
            if (!status.cnt_done) begin
               cmd.mem_rd = 1'b1;
            end else if (op == svm_pkg::OP_LOAD) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_dst = svm_pkg::WD_X;
               cmd.wr_src = svm_pkg::WS_DATA;
            end
         end
         svm_pkg::ST_MACC: cmd.mem_acc = 1'b1;
         svm_pkg::ST_MWR: cmd.mem_wr = !status.cnt_done;
         svm_pkg::ST_PUSH_CHK: begin
            if (status.push_ovf) begin
               cmd.set_trap   = 1'b1;
               cmd.trap_code  = svm_pkg::TRAP_OVERFLOW;
               cmd.reason_sel = svm_pkg::RS_SP;
            end else begin
               cmd.addr_setup = 1'b1;
               cmd.addr_sel   = svm_pkg::AS_SP_M8;
               cmd.len8       = 1'b1;
            end
         end
         svm_pkg::ST_PUSH_SP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_dst = svm_pkg::WD_SP;
            cmd.wr_src = svm_pkg::WS_ADDR;
            cmd.rd_idx = svm_pkg::RI_PC;
            cmd.ld_b   = (op == svm_pkg::OP_CALL) && !phase_ff;
         end
         svm_pkg::ST_CALL_BP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_dst = svm_pkg::WD_BP;
            cmd.wr_src = svm_pkg::WS_ADDR;
         end
         svm_pkg::ST_POP_CHK: begin
            if (status.pop_unf) begin
               cmd.set_trap   = 1'b1;
               cmd.trap_code  = svm_pkg::TRAP_UNDERFLOW;
               cmd.reason_sel = svm_pkg::RS_SP;
            end else begin
               cmd.addr_setup = 1'b1;
               cmd.addr_sel   = svm_pkg::AS_SP;
               cmd.len8       = 1'b1;
            end
         end
         svm_pkg::ST_POP_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = svm_pkg::WS_DATA;
            if (op == svm_pkg::OP_POP) cmd.wr_dst = svm_pkg::WD_X;
            else cmd.wr_dst = phase_ff ? svm_pkg::WD_BP : svm_pkg::WD_PC;
         end
         svm_pkg::ST_POP_SP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_dst = svm_pkg::WD_SP;
            cmd.wr_src = svm_pkg::WS_ADDR_P8;
         end
         svm_pkg::ST_FINISH: cmd.finish = status.out_free;
         default: cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> state_ff == svm_pkg::ST_DECODE)
      else $error("accepted request did not start decoding");
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_trap |=> state_ff == svm_pkg::ST_FINISH)
      else $error("execution continued after a trap");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == svm_pkg::ST_CALL_BP) |-> phase_ff && op == svm_pkg::OP_CALL)
      else $error("frame update outside the second call push");

endmodule

// ----- hdl/svm_datapath.sv -----
// Register file, byte memory, operand registers, iterative multiply/divide and
// result register of the stack VM execute unit. Depends on svm_pkg.
module svm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  svm_pkg::cmd_type    cmd,
   output svm_pkg::status_type status,
   input  logic [4:0]          req_opcode,
   input  logic [3:0]          req_reg_x,
   input  logic [3:0]          req_reg_y,
   input  logic [3:0]          req_reg_z,
   input  logic [63:0]         req_immediate,
   input  logic [7:0]          req_access_size,
   input  logic [31:0]         req_inst_addr,
   input  logic [31:0]         req_fallthrough_addr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_trap_code,
   output logic [63:0]         rsp_trap_reason,
   output logic [31:0]         rsp_next_pc,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam int RW = svm_pkg::RIDX_W;
   localparam int AW = svm_pkg::ADDR_W;

   logic [63:0]   rf_ff [svm_pkg::NUM_REGS];
   logic [7:0]    mem [svm_pkg::MEM_BYTES];

   logic [4:0]    op_ff;
   logic [RW-1:0] x_ff, y_ff, z_ff;
   logic [63:0]   imm_ff;
   logic [7:0]    size_ff;
   logic [31:0]   iaddr_ff;
   logic [63:0]   a_ff, b_ff, addr_ff, data_ff;
   logic [3:0]    cnt_ff, len_ff;
   logic [7:0]    mem_q_ff;
   logic          rd_ok_ff;
   logic [63:0]   r_ff, q_ff, m_ff;
   logic [5:0]    itc_ff;
   logic [3:0]    trap_code_ff;
   logic [63:0]   trap_reason_ff;
   logic [31:0]   npc_ff;
   logic          rsp_valid_ff;
   logic [3:0]    rsp_code_ff;
   logic [63:0]   rsp_reason_ff;
   logic [31:0]   rsp_npc_ff;
   logic [16:0]   stack_limit_ff;
   logic [31:0]   prog_len_ff;

   logic [RW-1:0] rd_idx, wr_idx;
   logic [63:0]   rd_val, sp_val, bp_val, wr_val, alu_val, unary_val, reason_val;
   logic [63:0]   byte_addr, end_addr;
   logic          byte_ok;
   logic [64:0]   div_rs, div_diff;
   logic [79:0]   mul_prod;
   logic [5:0]    itc_last;

   assign sp_val = rf_ff[svm_pkg::SP_IDX];
   assign bp_val = rf_ff[svm_pkg::BP_IDX];

   always_comb begin
      case (cmd.rd_idx)
         svm_pkg::RI_X:  rd_idx = x_ff;
         svm_pkg::RI_Y:  rd_idx = y_ff;
         svm_pkg::RI_Z:  rd_idx = z_ff;
         svm_pkg::RI_BP: rd_idx = svm_pkg::BP_IDX;
         svm_pkg::RI_PC: rd_idx = svm_pkg::PC_IDX;
         default:        rd_idx = x_ff;
      endcase
   end
   assign rd_val = rf_ff[rd_idx];

   always_comb begin
      case (op_ff)
         svm_pkg::OP_INC: unary_val = a_ff + 64'd1;
         svm_pkg::OP_DEC: unary_val = a_ff - 64'd1;
         svm_pkg::OP_NEG: unary_val = ~a_ff + 64'd1;
         default:         unary_val = ~a_ff;
      endcase
   end

   always_comb begin
      case (op_ff)
         svm_pkg::OP_ADD: alu_val = a_ff + b_ff;
         svm_pkg::OP_SUB: alu_val = a_ff - b_ff;
         svm_pkg::OP_MUL: alu_val = r_ff;
         svm_pkg::OP_DIV: alu_val = q_ff;
         svm_pkg::OP_MOD: alu_val = r_ff;
         svm_pkg::OP_AND: alu_val = a_ff & b_ff;
         svm_pkg::OP_OR:  alu_val = a_ff | b_ff;
         svm_pkg::OP_XOR: alu_val = a_ff ^ b_ff;
         svm_pkg::OP_SHL: alu_val = (b_ff[63:6] != '0) ? '0 : (a_ff << b_ff[5:0]);
         default:         alu_val = (b_ff[63:6] != '0) ? '0 : (a_ff >> b_ff[5:0]);
      endcase
   end

   always_comb begin
      case (cmd.wr_dst)
         svm_pkg::WD_X:  wr_idx = x_ff;
         svm_pkg::WD_SP: wr_idx = svm_pkg::SP_IDX;
         svm_pkg::WD_BP: wr_idx = svm_pkg::BP_IDX;
         default:        wr_idx = svm_pkg::PC_IDX;
      endcase
      case (cmd.wr_src)
         svm_pkg::WS_A:       wr_val = a_ff;
         svm_pkg::WS_IMM:     wr_val = imm_ff;
         svm_pkg::WS_ALU:     wr_val = alu_val;
         svm_pkg::WS_UNARY:   wr_val = unary_val;
         svm_pkg::WS_DATA:    wr_val = data_ff;
         svm_pkg::WS_ADDR:    wr_val = (cmd.wr_dst == svm_pkg::WD_BP) ? sp_val : addr_ff;
         svm_pkg::WS_ADDR_P8: wr_val = addr_ff + 64'd8;
         default:             wr_val = bp_val;
      endcase
   end

   assign end_addr = a_ff + {56'd0, size_ff};

   always_comb begin
      case (cmd.reason_sel)
         svm_pkg::RS_X:      reason_val = {{(64-RW){1'b0}}, x_ff};
         svm_pkg::RS_A:      reason_val = a_ff;
         svm_pkg::RS_SIZE:   reason_val = {56'd0, size_ff};
         svm_pkg::RS_A_SIZE: reason_val = end_addr;
         svm_pkg::RS_MEM:    reason_val = svm_pkg::MEM_END;
         svm_pkg::RS_IMM:    reason_val = imm_ff;
         svm_pkg::RS_SP:     reason_val = sp_val;
         default:            reason_val = {32'd0, iaddr_ff};
      endcase
   end

   assign byte_addr = addr_ff + {60'd0, cnt_ff};
   assign byte_ok   = byte_addr < svm_pkg::MEM_END;
   assign div_rs    = {r_ff, q_ff[63]};
   assign div_diff  = div_rs - {1'b0, b_ff};
   assign mul_prod  = m_ff * q_ff[15:0];
   assign itc_last  = (op_ff == svm_pkg::OP_MUL) ? 6'd3 : 6'd63;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < svm_pkg::NUM_REGS; i++) begin
            rf_ff[i] <= '0;
         end
         rf_ff[svm_pkg::SP_IDX] <= svm_pkg::MEM_END;
         rf_ff[svm_pkg::BP_IDX] <= svm_pkg::MEM_END;
      end else if (cmd.latch) begin
         rf_ff[svm_pkg::PC_IDX] <= {32'd0, req_fallthrough_addr};
      end else if (cmd.wr_en) begin
         rf_ff[wr_idx] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && byte_ok) begin
         mem[byte_addr[AW-1:0]] <= b_ff[{cnt_ff[2:0], 3'b000} +: 8];
      end
      mem_q_ff <= mem[byte_addr[AW-1:0]];
      rd_ok_ff <= byte_ok;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_opcode;
         x_ff     <= req_reg_x;
         y_ff     <= req_reg_y;
         z_ff     <= req_reg_z;
         imm_ff   <= req_immediate;
         size_ff  <= req_access_size;
         iaddr_ff <= req_inst_addr;
      end
      if (cmd.ld_a) a_ff <= rd_val;
      if (cmd.b_imm) b_ff <= imm_ff;
      else if (cmd.ld_b) b_ff <= rd_val;
      if (cmd.addr_setup) begin
         case (cmd.addr_sel)
            svm_pkg::AS_A:  addr_ff <= a_ff;
            svm_pkg::AS_SP: addr_ff <= sp_val;
            default:        addr_ff <= sp_val - 64'd8;
         endcase
         data_ff <= '0;
      end else if (cmd.mem_acc) begin
         data_ff[{cnt_ff[2:0], 3'b000} +: 8] <= rd_ok_ff ? mem_q_ff : 8'd0;
      end
      if (cmd.alu_start) begin
         r_ff <= '0;
         m_ff <= a_ff;
         q_ff <= (op_ff == svm_pkg::OP_MUL) ? b_ff : a_ff;
      end else if (cmd.alu_step) begin
         if (op_ff == svm_pkg::OP_MUL) begin
            r_ff <= r_ff + mul_prod[63:0];
            m_ff <= {m_ff[47:0], 16'd0};
            q_ff <= {16'd0, q_ff[63:16]};
         end else if (!div_diff[64]) begin
            r_ff <= div_diff[63:0];
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            r_ff <= div_rs[63:0];
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
      if (cmd.latch) begin
         trap_reason_ff <= '0;
         npc_ff         <= req_fallthrough_addr;
      end else begin
         if (cmd.set_trap) trap_reason_ff <= reason_val;
         if (cmd.set_npc) npc_ff <= a_ff[31:0];
      end
      if (cmd.finish) begin
         rsp_code_ff   <= trap_code_ff;
         rsp_reason_ff <= trap_reason_ff;
         rsp_npc_ff    <= npc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         len_ff         <= '0;
         itc_ff         <= '0;
         trap_code_ff   <= svm_pkg::TRAP_NONE;
         rsp_valid_ff   <= 1'b0;
         stack_limit_ff <= 17'd4096;
         prog_len_ff    <= '0;
      end else begin
         if (cmd.addr_setup) begin
            cnt_ff <= '0;
            len_ff <= cmd.len8 ? 4'd8 : size_ff[3:0];
         end else if (cmd.mem_acc || cmd.mem_wr) begin
            cnt_ff <= cnt_ff + 4'd1;
         end
         if (cmd.alu_start) itc_ff <= '0;
         else if (cmd.alu_step) itc_ff <= itc_ff + 6'd1;
         if (cmd.latch) trap_code_ff <= svm_pkg::TRAP_NONE;
         else if (cmd.set_trap) trap_code_ff <= cmd.trap_code;
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_index == svm_pkg::CSR_STACK_LIMIT)
            stack_limit_ff <= csr_wdata[16:0];
         if (csr_valid && csr_index == svm_pkg::CSR_PROGRAM_LENGTH)
            prog_len_ff <= csr_wdata;
      end
   end

   always_comb begin
      status.op         = op_ff;
      status.x_special  = (x_ff == svm_pkg::PC_IDX) || (x_ff == svm_pkg::BP_IDX);
      status.b_nz       = (b_ff != '0);
      status.a_ge_mem   = (a_ff >= svm_pkg::MEM_END);
      status.size_gt8   = (size_ff > 8'd8);
      status.end_ge_mem = (end_addr >= svm_pkg::MEM_END);
      status.a_ge_plen  = (a_ff >= {32'd0, prog_len_ff});
      status.push_ovf   = ((svm_pkg::MEM_END - sp_val) >= ({47'd0, stack_limit_ff} + 64'd8));
      status.pop_unf    = ((sp_val + 64'd8) > bp_val);
      status.cnt_done   = (cnt_ff == len_ff);
      status.div_zero   = (b_ff == '0);
      status.alu_done   = (itc_ff == itc_last);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trap_code   = rsp_code_ff;
   assign rsp_trap_reason = rsp_reason_ff;
   assign rsp_next_pc     = rsp_npc_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff || !rsp_stall)
      else $error("pending response overwritten");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= len_ff)
      else $error("byte counter ran past access length");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr || cmd.mem_acc) |-> cnt_ff < len_ff)
      else $error("byte access beyond length");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff == svm_pkg::TRAP_NONE) |-> rsp_reason_ff == '0)
      else $error("nonzero trap reason without a trap");

endmodule

// ----- hdl/stack_vm_instruction_execute_top.sv -----
// Top level of the stack VM execute unit: controller plus datapath.
// Depends on svm_pkg, svm_ctrl and svm_datapath.
//
//   Channel  Handshake              Carries
//   req      req_valid/req_stall    one decoded instruction
//   rsp      rsp_valid/rsp_stall    trap code, trap reason, next PC
//   csr      csr_valid/csr_ready    register index and write data
//
// One instruction is in flight at a time; req_stall is low only when idle.
// Loads, stores, push, pop, call and ret move one byte at a time through the memory port;
// multiply and divide/mod are iterative, and the divider is bit-serial.
// Reset is synchronous and also resets the register file.
// A stalled response is held while the next request is already accepted.
module stack_vm_instruction_execute_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_opcode,
   input  logic [3:0]  req_reg_x,
   input  logic [3:0]  req_reg_y,
   input  logic [3:0]  req_reg_z,
   input  logic [63:0] req_immediate,
   input  logic [7:0]  req_access_size,
   input  logic [31:0] req_inst_addr,
   input  logic [31:0] req_fallthrough_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_trap_code,
   output logic [63:0] rsp_trap_reason,
   output logic [31:0] rsp_next_pc,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   svm_pkg::cmd_type    cmd;
   svm_pkg::status_type status;

   svm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   svm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_opcode           (req_opcode),
      .req_reg_x            (req_reg_x),
      .req_reg_y            (req_reg_y),
      .req_reg_z            (req_reg_z),
      .req_immediate        (req_immediate),
      .req_access_size      (req_access_size),
      .req_inst_addr        (req_inst_addr),
      .req_fallthrough_addr (req_fallthrough_addr),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_trap_code        (rsp_trap_code),
      .rsp_trap_reason      (rsp_trap_reason),
      .rsp_next_pc          (rsp_next_pc),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

endmodule
